/* rtl/keyed_handle_map_top_macros.svh */
// Assertion macros for the keyed handle map block.
// Used by keyed_handle_map_top; expects i_clk and i_rst_n in scope.
`ifndef KEYED_HANDLE_MAP_TOP_MACROS_SVH
`define KEYED_HANDLE_MAP_TOP_MACROS_SVH

// same-cycle implication
`define KHM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define KHM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/khm_pkg.sv */
// Package for the keyed handle map: sizes, codes, memory request types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package khm_pkg;

    localparam int ENTRIES   = 2048;
    localparam int KEY_BYTES = 24;
    localparam int ADDR_W    = $clog2(ENTRIES);
    localparam int HANDLE_W  = 16;
    localparam int SLOT_W    = 11;
    localparam int STATUS_W  = 3;

    localparam logic [1:0] OP_ADD  = 2'd0;
    localparam logic [1:0] OP_DEL  = 2'd1;
    localparam logic [1:0] OP_FIND = 2'd2;

    localparam logic [STATUS_W-1:0] ST_DONE     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_PRESENT  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd4;

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [2:0][63:0]  t_key;

    typedef struct packed {
        logic                valid;
        logic [HANDLE_W-1:0] handle;
    } t_meta;

    typedef struct packed {
        t_addr rd_addr;
        logic  wr_meta;
        logic  wr_key;
        t_addr wr_addr;
        t_meta wr_meta_data;
        t_key  wr_key_data;
    } t_mem_req;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_RESP
    } t_state;

endpackage

`default_nettype wire

/* rtl/khm_store.sv */
// Entry storage: metadata memory (valid, handle) and key memory.
// One read and one write port each, registered read data. Uses khm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module khm_store (
    input  wire               i_clk,
    input  khm_pkg::t_mem_req i_req,
    output khm_pkg::t_meta    o_rd_meta,
    output khm_pkg::t_key     o_rd_key
);

    khm_pkg::t_meta meta_mem [khm_pkg::ENTRIES];
    khm_pkg::t_key  key_mem  [khm_pkg::ENTRIES];

    khm_pkg::t_meta r_rd_meta;
    khm_pkg::t_key  r_rd_key;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_meta) begin
            meta_mem[i_req.wr_addr] <= i_req.wr_meta_data;
        end
        r_rd_meta <= meta_mem[i_req.rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_req.wr_key) begin
            key_mem[i_req.wr_addr] <= i_req.wr_key_data;
        end
        r_rd_key <= key_mem[i_req.rd_addr];
    end

    assign o_rd_meta = r_rd_meta;
    assign o_rd_key  = r_rd_key;

endmodule

`default_nettype wire

/* rtl/keyed_handle_map_top.sv */
// Keyed handle map: add, delete and find items scan the entries, one entry per cycle;
// delete scans all entries, add and find stop early on a hit.
// Empty keys on add and find, and unused opcodes, skip the scan. One item at a time.
// The scan over the single-read-port entry memory sets the rate.
// Reset: synchronous; a clearing pass over all ENTRIES (2048) entries then runs
// and the input is not ready until it ends.
`timescale 1ns / 1ps
`default_nettype none
`include "keyed_handle_map_top_macros.svh"

module keyed_handle_map_top (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_in_valid,
    output logic                             o_in_ready,
    input  wire  [1:0]                       i_opcode,
    input  wire  [63:0]                      i_key_word0,
    input  wire  [63:0]                      i_key_word1,
    input  wire  [63:0]                      i_key_word2,
    input  wire  [khm_pkg::HANDLE_W-1:0]     i_handle,
    output logic                             o_out_valid,
    input  wire                              i_out_ready,
    output logic [khm_pkg::STATUS_W-1:0]     o_status,
    output logic [khm_pkg::HANDLE_W-1:0]     o_handle_out,
    output logic [khm_pkg::SLOT_W-1:0]       o_slot_index
);

    localparam khm_pkg::t_addr LAST = khm_pkg::ADDR_W'(khm_pkg::ENTRIES - 1);

    function automatic khm_pkg::t_key norm_key(input khm_pkg::t_key raw);
        khm_pkg::t_key k;
        logic          run;
        logic [7:0]    bt;
        k   = '0;
        run = 1'b1;
        for (int b = 0; b < 24; b++) begin
            bt = raw[b >> 3][8 * (b & 7) +: 8];
            if (b >= khm_pkg::KEY_BYTES || bt == 8'd0) begin
                run = 1'b0;
            end
            if (run) begin
                k[b >> 3][8 * (b & 7) +: 8] = bt;
            end
        end
        return k;
    endfunction

    khm_pkg::t_state r_state, n_state;
    khm_pkg::t_addr  r_scan_addr, n_scan_addr;
    logic            r_issue_done, n_issue_done;
    logic            r_chk_valid, n_chk_valid;
    khm_pkg::t_addr  r_chk_addr, n_chk_addr;

    logic [1:0]                  r_op;
    khm_pkg::t_key               r_key;
    logic [khm_pkg::HANDLE_W-1:0] r_handle;
    logic                        r_have_free, n_have_free;
    khm_pkg::t_addr              r_free_slot, n_free_slot;
    logic                        r_any, n_any;
    khm_pkg::t_addr              r_first, n_first;

    logic [khm_pkg::STATUS_W-1:0] r_res_status, n_res_status;
    logic [khm_pkg::HANDLE_W-1:0] r_res_handle, n_res_handle;
    logic [khm_pkg::SLOT_W-1:0]   r_res_slot, n_res_slot;

    logic                         r_out_valid;
    logic [khm_pkg::STATUS_W-1:0] r_status;
    logic [khm_pkg::HANDLE_W-1:0] r_handle_out;
    logic [khm_pkg::SLOT_W-1:0]   r_slot_index;

    khm_pkg::t_mem_req mem_req;
    khm_pkg::t_meta    rd_meta;
    khm_pkg::t_key     rd_key;

    khm_pkg::t_key in_key;
    logic          in_accept;
    logic          scan_finish;
    logic          resp_load;
    logic          chk_last;
    logic          key_hit;
    logic          hdl_hit;

    khm_store u_store (
        .i_clk     (i_clk),
        .i_req     (mem_req),
        .o_rd_meta (rd_meta),
        .o_rd_key  (rd_key)
    );

    assign in_key    = norm_key({i_key_word2, i_key_word1, i_key_word0});
    assign o_in_ready = (r_state == khm_pkg::S_IDLE);
    assign in_accept = i_in_valid && o_in_ready;
    assign resp_load = (r_state == khm_pkg::S_RESP) && (!r_out_valid || i_out_ready);
    assign chk_last  = r_chk_valid && (r_chk_addr == LAST);
    assign key_hit   = rd_meta.valid && (rd_key == r_key);
    assign hdl_hit   = rd_meta.valid && (rd_meta.handle == r_handle);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            khm_pkg::S_CLEAR: begin
                if (r_scan_addr == LAST) begin
                    n_state = khm_pkg::S_IDLE;
                end
            end
            khm_pkg::S_IDLE: begin
                if (in_accept) begin
                    if ((i_opcode == khm_pkg::OP_DEL) ||
                        ((i_opcode == khm_pkg::OP_ADD || i_opcode == khm_pkg::OP_FIND) &&
                         in_key[0][7:0] != 8'd0)) begin
                        n_state = khm_pkg::S_SCAN;
                    end else begin
                        n_state = khm_pkg::S_RESP;
                    end
                end
            end
            khm_pkg::S_SCAN: begin
                if (scan_finish) begin
                    n_state = khm_pkg::S_RESP;
                end
            end
            khm_pkg::S_RESP: begin
                if (resp_load) begin
                    n_state = khm_pkg::S_IDLE;
                end
            end
            default: n_state = khm_pkg::S_IDLE;
        endcase
    end

    // datapath and memory requests
    always_comb begin
        mem_req      = '0;
        n_scan_addr  = r_scan_addr;
        n_issue_done = r_issue_done;
        n_chk_valid  = 1'b0;
        n_chk_addr   = r_chk_addr;
        n_have_free  = r_have_free;
        n_free_slot  = r_free_slot;
        n_any        = r_any;
        n_first      = r_first;
        n_res_status = r_res_status;
        n_res_handle = r_res_handle;
        n_res_slot   = r_res_slot;
        scan_finish  = 1'b0;
        mem_req.rd_addr = r_scan_addr;

        case (r_state)
            khm_pkg::S_CLEAR: begin
                mem_req.wr_meta = 1'b1;
                mem_req.wr_addr = r_scan_addr;
                n_scan_addr     = r_scan_addr + 1'b1;
            end
            khm_pkg::S_IDLE: begin
                n_scan_addr  = '0;
                n_issue_done = 1'b0;
                n_have_free  = 1'b0;
                n_any        = 1'b0;
                n_res_status = khm_pkg::ST_NOTFOUND;
                n_res_handle = '0;
                n_res_slot   = '0;
                if ((i_opcode == khm_pkg::OP_ADD || i_opcode == khm_pkg::OP_FIND) &&
                    in_key[0][7:0] == 8'd0) begin
                    n_res_status = khm_pkg::ST_EMPTY;
                end
            end
            khm_pkg::S_SCAN: begin
                if (r_chk_valid) begin
                    case (r_op)
                        khm_pkg::OP_ADD: begin
                            if (key_hit && hdl_hit) begin
                                scan_finish  = 1'b1;
                                n_res_status = khm_pkg::ST_PRESENT;
                                n_res_slot   = khm_pkg::SLOT_W'(r_chk_addr);
                            end else begin
                                if (!rd_meta.valid && !r_have_free) begin
                                    n_have_free = 1'b1;
                                    n_free_slot = r_chk_addr;
                                end
                                if (chk_last) begin
                                    scan_finish = 1'b1;
                                    if (n_have_free) begin
                                        mem_req.wr_meta      = 1'b1;
                                        mem_req.wr_key       = 1'b1;
                                        mem_req.wr_addr      = n_free_slot;
                                        mem_req.wr_meta_data = '{valid: 1'b1, handle: r_handle};
                                        mem_req.wr_key_data  = r_key;
                                        n_res_status = khm_pkg::ST_DONE;
                                        n_res_slot   = khm_pkg::SLOT_W'(n_free_slot);
                                    end else begin
                                        n_res_status = khm_pkg::ST_FULL;
                                    end
                                end
                            end
                        end
                        khm_pkg::OP_DEL: begin
                            if (hdl_hit) begin
                                mem_req.wr_meta = 1'b1;
                                mem_req.wr_addr = r_chk_addr;
                                if (!r_any) begin
                                    n_any   = 1'b1;
                                    n_first = r_chk_addr;
                                end
                            end
                            if (chk_last) begin
                                scan_finish = 1'b1;
                                if (n_any) begin
                                    n_res_status = khm_pkg::ST_DONE;
                                    n_res_slot   = khm_pkg::SLOT_W'(n_first);
                                end
                            end
                        end
                        khm_pkg::OP_FIND: begin
                            if (key_hit) begin
                                scan_finish  = 1'b1;
                                n_res_status = khm_pkg::ST_DONE;
                                n_res_handle = rd_meta.handle;
                                n_res_slot   = khm_pkg::SLOT_W'(r_chk_addr);
                            end else if (chk_last) begin
                                scan_finish = 1'b1;
                            end
                        end
                        default: scan_finish = 1'b1;
                    endcase
                end
                if (!r_issue_done && !scan_finish) begin
                    n_chk_valid = 1'b1;
                    n_chk_addr  = r_scan_addr;
                    n_scan_addr = r_scan_addr + 1'b1;
                    if (r_scan_addr == LAST) begin
                        n_issue_done = 1'b1;
                    end
                end
            end
            khm_pkg::S_RESP: begin
                n_scan_addr = '0;
            end
            default: begin
                n_scan_addr = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= khm_pkg::S_CLEAR;
            r_scan_addr  <= '0;
            r_issue_done <= 1'b0;
            r_chk_valid  <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_scan_addr  <= n_scan_addr;
            r_issue_done <= n_issue_done;
            r_chk_valid  <= n_chk_valid;
            if (resp_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_chk_addr   <= n_chk_addr;
        r_have_free  <= n_have_free;
        r_free_slot  <= n_free_slot;
        r_any        <= n_any;
        r_first      <= n_first;
        r_res_status <= n_res_status;
        r_res_handle <= n_res_handle;
        r_res_slot   <= n_res_slot;
        if (in_accept) begin
            r_op     <= i_opcode;
            r_key    <= in_key;
            r_handle <= i_handle;
        end
        if (resp_load) begin
            r_status     <= r_res_status;
            r_handle_out <= r_res_handle;
            r_slot_index <= r_res_slot;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_handle_out = r_handle_out;
    assign o_slot_index = r_slot_index;

    `KHM_ASSERT_NEXT(a_busy_after_accept, in_accept, !o_in_ready, "ready after item accept")
    `KHM_ASSERT_NOW(a_full_slot_zero, o_out_valid && o_status == khm_pkg::ST_FULL, o_slot_index == '0, "full result with slot")
    `KHM_ASSERT_NOW(a_handle_only_find, o_out_valid && o_status != khm_pkg::ST_DONE, o_handle_out == '0, "handle on non-done result")
    `KHM_ASSERT_NEXT(a_chk_in_scan, r_state != khm_pkg::S_SCAN, !r_chk_valid, "compare outside scan")

endmodule

`default_nettype wire

/* tb/tb_keyed_handle_map_top.sv */
`timescale 1ns / 1ps
// Testbench for keyed_handle_map_top: a directed table, then random add/delete/find and unused-opcode
// traffic, each result compared against its scripted value or a behavioral model of the slot table.
// Depends on khm_pkg and keyed_handle_map_top only.

module tb_keyed_handle_map_top;
    import khm_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int RAND_ITEMS  = 265;
    localparam int STALL_LIMIT = 12000;
    localparam int TAIL_CYCLES = 64;
    localparam int KEY_POOL    = 16;
    localparam int HANDLE_POOL = 6;
    localparam logic [63:0] ALL1 = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [HANDLE_W-1:0] handle;
        logic [SLOT_W-1:0]   slot;
    } t_outcome;

    typedef struct {
        logic [1:0]          op;
        t_key                key;
        logic [HANDLE_W-1:0] handle;
        bit                  typed;
        t_outcome            exp;
    } t_request;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    logic [1:0]          i_opcode;
    logic [63:0]         i_key_word0;
    logic [63:0]         i_key_word1;
    logic [63:0]         i_key_word2;
    logic [HANDLE_W-1:0] i_handle;
    logic                o_out_valid;
    logic                i_out_ready;
    logic [STATUS_W-1:0] o_status;
    logic [HANDLE_W-1:0] o_handle_out;
    logic [SLOT_W-1:0]   o_slot_index;

    bit                  map_valid [ENTRIES];
    t_key                map_key [ENTRIES];
    logic [HANDLE_W-1:0] map_handle [ENTRIES];
    t_outcome            results_due [$];
    t_request            cur_req;
    bit                  no_idle;
    int                  errors;
    int                  stall_cycles;

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    keyed_handle_map_top uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_opcode     (i_opcode),
        .i_key_word0  (i_key_word0),
        .i_key_word1  (i_key_word1),
        .i_key_word2  (i_key_word2),
        .i_handle     (i_handle),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_status     (o_status),
        .o_handle_out (o_handle_out),
        .o_slot_index (o_slot_index)
    );

    function automatic t_outcome outcome(logic [STATUS_W-1:0] st, logic [HANDLE_W-1:0] h,
                                         int slot);
        t_outcome o;
        o.status = st;
        o.handle = h;
        o.slot   = slot[SLOT_W-1:0];
        return o;
    endfunction

    function automatic t_request req(logic [1:0] op, logic [63:0] k0, logic [63:0] k1,
                                     logic [63:0] k2, logic [HANDLE_W-1:0] h, bit typed,
                                     logic [STATUS_W-1:0] st, logic [HANDLE_W-1:0] hout,
                                     int slot);
        t_request r;
        r.op     = op;
        r.key    = {k2, k1, k0};
        r.handle = h;
        r.typed  = typed;
        r.exp    = outcome(st, hout, slot);
        return r;
    endfunction

    // key ends at the first zero byte; everything after it counts as zero
    function automatic t_key trim_key(t_key raw);
        t_key       key;
        bit         ended;
        logic [7:0] val;
        key   = '0;
        ended = 1'b0;
        for (int b = 0; b < 24; b++) begin
            val = raw[b / 8][(b % 8) * 8 +: 8];
            if (b >= KEY_BYTES || val == 8'd0) ended = 1'b1;
            if (!ended) key[b / 8][(b % 8) * 8 +: 8] = val;
        end
        return key;
    endfunction

    function automatic t_outcome map_apply(logic [1:0] op, t_key raw, logic [HANDLE_W-1:0] h);
        t_key key;
        bit   have_free;
        int   free_slot;
        bit   any;
        int   first;
        key       = trim_key(raw);
        have_free = 1'b0;
        free_slot = 0;
        any       = 1'b0;
        first     = 0;
        case (op)
            OP_ADD: begin
                if (key[0][7:0] == 8'd0) return outcome(ST_EMPTY, '0, 0);
                for (int i = 0; i < ENTRIES; i++) begin
                    if (map_valid[i]) begin
                        if (map_handle[i] == h && map_key[i] == key)
                            return outcome(ST_PRESENT, '0, i);
                    end else if (!have_free) begin
                        have_free = 1'b1;
                        free_slot = i;
                    end
                end
                if (!have_free) return outcome(ST_FULL, '0, 0);
                map_valid[free_slot]  = 1'b1;
                map_key[free_slot]    = key;
                map_handle[free_slot] = h;
                return outcome(ST_DONE, '0, free_slot);
            end
            OP_DEL: begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (map_valid[i] && map_handle[i] == h) begin
                        map_valid[i] = 1'b0;
                        if (!any) begin
                            any   = 1'b1;
                            first = i;
                        end
                    end
                end
                return any ? outcome(ST_DONE, '0, first) : outcome(ST_NOTFOUND, '0, 0);
            end
            OP_FIND: begin
                if (key[0][7:0] == 8'd0) return outcome(ST_EMPTY, '0, 0);
                for (int i = 0; i < ENTRIES; i++) begin
                    if (map_valid[i] && map_key[i] == key)
                        return outcome(ST_DONE, map_handle[i], i);
                end
                return outcome(ST_NOTFOUND, '0, 0);
            end
            default: return outcome(ST_NOTFOUND, '0, 0);
        endcase
    endfunction

    task automatic report_error(input string msg);
        if (errors < 100) $display("ERROR @%0t: %s", $time, msg);
        errors++;
    endtask

    task automatic send(input t_request r);
        @(negedge i_clk);
        if (!no_idle && $urandom_range(0, 99) < 16) begin
            i_in_valid <= 1'b0;
            do @(negedge i_clk); while ($urandom_range(0, 99) < 16);
        end
        cur_req = r;
        i_opcode    <= r.op;
        i_key_word0 <= r.key[0];
        i_key_word1 <= r.key[1];
        i_key_word2 <= r.key[2];
        i_handle    <= r.handle;
        i_in_valid  <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic wait_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (results_due.size() != 0) @(posedge i_clk);
    endtask

    always @(negedge i_clk) begin
        i_out_ready <= no_idle || ($urandom_range(0, 99) >= 16);
    end

    always @(posedge i_clk) begin : result_check
        t_outcome want;
        t_outcome model;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (results_due.size() == 0) begin
                    report_error($sformatf("result with none pending: st=%0d h=%h slot=%0d",
                                           o_status, o_handle_out, o_slot_index));
                end else begin
                    want = results_due.pop_front();
                    if (o_status !== want.status)
                        report_error($sformatf("status %0d, want %0d", o_status, want.status));
                    if (o_handle_out !== want.handle)
                        report_error($sformatf("handle_out %h, want %h",
                                               o_handle_out, want.handle));
                    if (o_slot_index !== want.slot)
                        report_error($sformatf("slot_index %0d, want %0d",
                                               o_slot_index, want.slot));
                end
            end
            if (i_in_valid && o_in_ready) begin
                model = map_apply(i_opcode, {i_key_word2, i_key_word1, i_key_word0}, i_handle);
                results_due.push_back(cur_req.typed ? cur_req.exp : model);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("keyed_handle_map_top verification failed");
            $finish;
        end
    end

    initial begin : stimulus
        t_request            script [$];
        t_request            r;
        t_key                pool_key [KEY_POOL];
        int                  pool_len [KEY_POOL];
        logic [HANDLE_W-1:0] pool_handle [HANDLE_POOL];
        int                  n;
        int                  pick;
        int                  k;
        int                  pos;
        logic [7:0]          val;

        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_opcode     = OP_ADD;
        i_key_word0  = '0;
        i_key_word1  = '0;
        i_key_word2  = '0;
        i_handle     = '0;
        i_out_ready  = 1'b0;
        no_idle      = 1'b0;
        errors       = 0;
        stall_cycles = 0;
        cur_req.typed = 1'b0;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty table, empty keys, unused opcode
        script.push_back(req(OP_FIND, 64'h41, 0, 0, 16'h0000, 1, ST_NOTFOUND, 0, 0));
        script.push_back(req(OP_DEL, 0, 0, 0, 16'h0000, 1, ST_NOTFOUND, 0, 0));
        script.push_back(req(OP_ADD, 64'hFFFF_FFFF_FFFF_FF00, ALL1, ALL1, 16'h1234, 1,
                             ST_EMPTY, 0, 0));
        script.push_back(req(OP_FIND, 0, ALL1, ALL1, 16'hFFFF, 1, ST_EMPTY, 0, 0));
        script.push_back(req(OP_UNUSED, ALL1, ALL1, ALL1, 16'hFFFF, 1, ST_NOTFOUND, 0, 0));
        // full-length key, duplicate pair, same key with second handle
        script.push_back(req(OP_ADD, ALL1, ALL1, ALL1, 16'hFFFF, 1, ST_DONE, 0, 0));
        script.push_back(req(OP_ADD, ALL1, ALL1, ALL1, 16'hFFFF, 1, ST_PRESENT, 0, 0));
        script.push_back(req(OP_ADD, ALL1, ALL1, ALL1, 16'h0000, 1, ST_DONE, 0, 1));
        script.push_back(req(OP_FIND, ALL1, ALL1, ALL1, 16'h0000, 1, ST_DONE, 16'hFFFF, 0));
        // junk after the terminating zero byte must be dropped
        script.push_back(req(OP_ADD, 64'h1122_3344_5566_0041, 64'hDEAD_BEEF_0BAD_F00D, ALL1,
                             16'h0001, 0, ST_DONE, 0, 0));
        script.push_back(req(OP_FIND, 64'h41, 0, 0, 16'h0000, 0, ST_DONE, 0, 0));
        script.push_back(req(OP_ADD, 64'h41, 0, 0, 16'h0001, 0, ST_DONE, 0, 0));
        script.push_back(req(OP_ADD, 64'h0101_0101_0101_0101, 0, 64'h55AA_55AA_55AA_55AA,
                             16'h8000, 0, ST_DONE, 0, 0));
        script.push_back(req(OP_FIND, 64'h0101_0101_0101_0101, 0, 0, 16'h0000, 0,
                             ST_DONE, 0, 0));
        // deletes and slot reuse
        script.push_back(req(OP_DEL, 0, 0, 0, 16'hFFFF, 1, ST_DONE, 0, 0));
        script.push_back(req(OP_FIND, ALL1, ALL1, ALL1, 16'h0000, 0, ST_DONE, 0, 0));
        script.push_back(req(OP_ADD, 64'h42, 0, 0, 16'h0002, 0, ST_DONE, 0, 0));
        script.push_back(req(OP_DEL, ALL1, ALL1, ALL1, 16'h0000, 0, ST_DONE, 0, 0));
        script.push_back(req(OP_DEL, 0, 0, 0, 16'h0000, 1, ST_NOTFOUND, 0, 0));
        script.push_back(req(OP_FIND, ALL1, ALL1, ALL1, 16'h0000, 0, ST_DONE, 0, 0));
        script.push_back(req(OP_ADD, 64'h7F7F_7F7F_7F7F_7F7F, 64'h7F7F_7F7F_7F7F_7F7F,
                             64'h7F7F_7F7F_7F7F_7F7F, 16'hAAAA, 0, ST_DONE, 0, 0));
        script.push_back(req(OP_ADD, 64'h43, 0, 0, 16'hAAAA, 0, ST_DONE, 0, 0));
        script.push_back(req(OP_DEL, 0, 0, 0, 16'hAAAA, 0, ST_DONE, 0, 0));
        script.push_back(req(OP_FIND, 64'h43, 0, 0, 16'h0000, 0, ST_DONE, 0, 0));
        script.push_back(req(OP_UNUSED, 0, 0, 0, 16'h0000, 1, ST_NOTFOUND, 0, 0));

        foreach (script[j]) send(script[j]);
        wait_results();

        // key pool: odd entries differ from their neighbor in a single byte
        for (k = 0; k < KEY_POOL; k++) begin
            if (k % 2 == 1) begin
                pool_key[k] = pool_key[k - 1];
                pool_len[k] = pool_len[k - 1];
                pos = $urandom_range(0, pool_len[k] - 1);
                val = pool_key[k][pos / 8][(pos % 8) * 8 +: 8];
                pool_key[k][pos / 8][(pos % 8) * 8 +: 8] = (val % 255) + 1;
            end else begin
                pool_len[k] = (k % 4 == 0) ? 24 : $urandom_range(1, 12);
                pool_key[k] = '0;
                for (pos = 0; pos < pool_len[k]; pos++)
                    pool_key[k][pos / 8][(pos % 8) * 8 +: 8] = $urandom_range(1, 255);
            end
        end
        for (k = 0; k < HANDLE_POOL; k++) pool_handle[k] = $urandom_range(0, 65535);

        for (n = 0; n < RAND_ITEMS; n++) begin
            no_idle = (n >= 100 && n < 160);
            if (n % 50 == 49) wait_results();
            r.typed  = 1'b0;
            r.exp    = '0;
            pick     = $urandom_range(0, 99);
            k        = $urandom_range(0, KEY_POOL - 1);
            r.key    = pool_key[k];
            r.handle = pool_handle[$urandom_range(0, HANDLE_POOL - 1)];
            if ($urandom_range(0, 3) == 0) begin
                for (pos = pool_len[k] + 1; pos < 24; pos++)
                    r.key[pos / 8][(pos % 8) * 8 +: 8] = $urandom_range(0, 255);
            end
            if (pick < 40) begin
                r.op = OP_ADD;
            end else if (pick < 60) begin
                r.op = OP_DEL;
                if ($urandom_range(0, 7) == 0) r.handle = $urandom_range(0, 65535);
            end else if (pick < 92) begin
                r.op = OP_FIND;
            end else begin
                r.key = {{$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom}};
                r.handle = $urandom_range(0, 65535);
                case (pick % 4)
                    0: begin
                        r.op = OP_ADD;
                        r.key[0][7:0] = 8'd0;
                    end
                    1: begin
                        r.op = OP_FIND;
                        r.key[0][7:0] = 8'd0;
                    end
                    2: r.op = OP_UNUSED;
                    default: r.op = $urandom_range(0, 3);
                endcase
            end
            send(r);
        end
        no_idle = 1'b0;

        wait_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (errors == 0)
            $display("keyed_handle_map_top verification clean");
        else
            $display("keyed_handle_map_top verification failed");
        $finish;
    end

endmodule

/* keyed_handle_map_top.f */
+incdir+rtl
rtl/khm_pkg.sv
rtl/khm_store.sv
rtl/keyed_handle_map_top.sv
tb/tb_keyed_handle_map_top.sv
